### rtl/rv32m_multiply_divide_unit_macros.svh
// ============================================================================
// RV32M multiply/divide unit assertion macros
// Shared concurrent assertion wrappers; empty when synthesising.
// ============================================================================
`ifndef RV32M_MULTIPLY_DIVIDE_UNIT_MACROS_SVH
`define RV32M_MULTIPLY_DIVIDE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property outside reset
`define RMDU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property at every edge, reset included
`define RMDU_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMDU_ASSERT(label, clk, rst, prop, msg)
`define RMDU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### rtl/rmdu_pkg.sv
// ============================================================================
// RV32M multiply/divide unit package
// Operation codes, decode constants and the pipeline record.
// ============================================================================
`default_nettype none
package rmdu_pkg;

   localparam int unsigned XLEN      = 32;
   localparam int unsigned DIV_STEPS = XLEN;

   localparam logic [XLEN-1:0] OPCODE_MASK  = 32'hfe00007f;
   localparam logic [XLEN-1:0] OPCODE_MATCH = 32'h02000033;
   localparam logic [XLEN-1:0] ALL_ONES     = 32'hffffffff;
   localparam logic [XLEN-1:0] MOST_NEG     = 32'h80000000;

   typedef enum logic [2:0] {
      OP_MUL    = 3'd0,
      OP_MULH   = 3'd1,
      OP_MULHSU = 3'd2,
      OP_MULHU  = 3'd3,
      OP_DIV    = 3'd4,
      OP_DIVU   = 3'd5,
      OP_REM    = 3'd6,
      OP_REMU   = 3'd7
   } op_type;

   // Record carried from stage to stage
   typedef struct packed {
      logic              handled;
      logic              write_enable;
      logic [4:0]        dest_register;
      op_type            op;
      logic              neg_res;
      logic              neg_rem;
      logic              div_zero;
      logic              overflow;
      logic [XLEN-1:0]   raw_a;
      logic [XLEN-1:0]   mag_a;
      logic [XLEN-1:0]   mag_b;
      logic [XLEN-1:0]   quo;
      logic [XLEN-1:0]   rem;
      logic [2*XLEN-1:0] prod;
   } pipe_type;

endpackage
`default_nettype wire

### rtl/rmdu_decode.sv
// ============================================================================
// RV32M decode stage
// Matches the M-extension pattern and prepares operand magnitudes and signs.
// ============================================================================
`default_nettype none
module rmdu_decode import rmdu_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output      logic            in_ready,
   input  wire logic [XLEN-1:0] instruction,
   input  wire logic [XLEN-1:0] first_operand,
   input  wire logic [XLEN-1:0] second_operand,
   output      logic            out_valid,
   input  wire logic            out_ready,
   output      pipe_type        out_data
);

   logic     valid_ff;
   pipe_type data_ff;
   pipe_type data_in;

   // Work out operation, signs and magnitudes
   always_comb begin
      logic   match;
      op_type op;
      logic   sa;
      logic   sb;
      match = (instruction & OPCODE_MASK) == OPCODE_MATCH;
      op    = op_type'(instruction[14:12]);
      sa    = 1'b0;
      sb    = 1'b0;
      case (op)
         OP_MULH: begin
            sa = first_operand[XLEN-1];
            sb = second_operand[XLEN-1];
         end
         OP_MULHSU: begin
            sa = first_operand[XLEN-1];
         end
         OP_DIV, OP_REM: begin
            sa = first_operand[XLEN-1];
            sb = second_operand[XLEN-1];
         end
         default: begin
            sa = 1'b0;
         end
      endcase
      data_in               = '0;
      data_in.handled       = match;
      data_in.dest_register = match ? instruction[11:7] : 5'd0;
      data_in.write_enable  = match && (instruction[11:7] != 5'd0);
      data_in.op            = op;
      data_in.raw_a         = first_operand;
      data_in.mag_a         = sa ? (XLEN'(0) - first_operand) : first_operand;
      data_in.mag_b         = sb ? (XLEN'(0) - second_operand) : second_operand;
      data_in.div_zero      = second_operand == '0;
      data_in.overflow      = (op == OP_DIV || op == OP_REM) &&
                              first_operand == MOST_NEG && second_operand == ALL_ONES;
      data_in.neg_res       = op[2] ? (sa ^ sb) : (sa ^ sb);
      data_in.neg_rem       = op[2] && sa;
   end

   assign in_ready = !valid_ff || out_ready;

   // Advance valid under control reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Hold payload until the next transfer
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

### rtl/rmdu_mul_stage.sv
// ============================================================================
// RV32M multiply stage
// Forms the unsigned product of the magnitudes and seeds the divider.
// ============================================================================
`default_nettype none
module rmdu_mul_stage import rmdu_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output      logic     in_ready,
   input  wire pipe_type in_data,
   output      logic     out_valid,
   input  wire logic     out_ready,
   output      pipe_type out_data
);

   logic     valid_ff;
   pipe_type data_ff;
   pipe_type data_in;

   // Multiply and seed the divider registers
   always_comb begin
      data_in      = in_data;
      data_in.prod = {{XLEN{1'b0}}, in_data.mag_a} * {{XLEN{1'b0}}, in_data.mag_b};
      data_in.quo  = in_data.mag_a;
      data_in.rem  = '0;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

### rtl/rmdu_div_step.sv
// ============================================================================
// RV32M divider step
// One restoring division step: one quotient bit per stage.
// ============================================================================
`default_nettype none
module rmdu_div_step import rmdu_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output      logic     in_ready,
   input  wire pipe_type in_data,
   output      logic     out_valid,
   input  wire logic     out_ready,
   output      pipe_type out_data
);

   logic     valid_ff;
   pipe_type data_ff;
   pipe_type data_in;

   // Shift in the next dividend bit and subtract when it fits
   always_comb begin
      logic [XLEN:0] rem_sh;
      logic [XLEN:0] diff;
      rem_sh  = {in_data.rem, in_data.quo[XLEN-1]};
      diff    = rem_sh - {1'b0, in_data.mag_b};
      data_in = in_data;
      if (!diff[XLEN]) begin
         data_in.rem = diff[XLEN-1:0];
         data_in.quo = {in_data.quo[XLEN-2:0], 1'b1};
      end else begin
         data_in.rem = rem_sh[XLEN-1:0];
         data_in.quo = {in_data.quo[XLEN-2:0], 1'b0};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

### rtl/rmdu_finish.sv
// ============================================================================
// RV32M result stage
// Applies signs and special cases and holds the result for transfer.
// ============================================================================
`default_nettype none
module rmdu_finish import rmdu_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output      logic            in_ready,
   input  wire pipe_type        in_data,
   output      logic            out_valid,
   input  wire logic            out_ready,
   output      logic            handled,
   output      logic            write_enable,
   output      logic [4:0]      dest_register,
   output      logic [XLEN-1:0] write_value
);

   logic            valid_ff;
   logic            handled_ff;
   logic            write_enable_ff;
   logic [4:0]      dest_register_ff;
   logic [XLEN-1:0] write_value_ff;
   logic [XLEN-1:0] value_in;

   // Select the final value
   always_comb begin
      logic [2*XLEN-1:0] prod;
      prod = in_data.neg_res ? ((2*XLEN)'(0) - in_data.prod) : in_data.prod;
      if (!in_data.op[2]) begin
         value_in = (in_data.op == OP_MUL) ? prod[XLEN-1:0] : prod[2*XLEN-1:XLEN];
      end else if (in_data.div_zero) begin
         value_in = in_data.op[1] ? in_data.raw_a : ALL_ONES;
      end else if (in_data.overflow) begin
         value_in = in_data.op[1] ? '0 : MOST_NEG;
      end else if (in_data.op[1]) begin
         value_in = in_data.neg_rem ? (XLEN'(0) - in_data.rem) : in_data.rem;
      end else begin
         value_in = in_data.neg_res ? (XLEN'(0) - in_data.quo) : in_data.quo;
      end
      if (!in_data.handled) begin
         value_in = '0;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         handled_ff       <= in_data.handled;
         write_enable_ff  <= in_data.write_enable;
         dest_register_ff <= in_data.dest_register;
         write_value_ff   <= value_in;
      end
   end

   assign out_valid     = valid_ff;
   assign handled       = handled_ff;
   assign write_enable  = write_enable_ff;
   assign dest_register = dest_register_ff;
   assign write_value   = write_value_ff;

endmodule
`default_nettype wire

### rtl/rv32m_multiply_divide_unit.sv
// ============================================================================
// RV32M multiply/divide unit
// Pipelined decode, multiply and one-bit-per-stage division of RV32M words.
// ============================================================================
//  channel  direction  payload
//  req      in         instruction, first_operand, second_operand
//  rsp      out        handled, write_enable, dest_register, write_value
//
// One transfer in per cycle while no stage stalls; each item passes from request to result through
// decode, multiply, 32 restoring divider steps and the result stage.
// Every stage has its own ready, so bubbles close up behind a stalled result.
// Reset clears the valid bits of all stages; payload registers are not reset.
// ============================================================================
`default_nettype none
`include "rv32m_multiply_divide_unit_macros.svh"
module rv32m_multiply_divide_unit import rmdu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // instruction [31:0], first_operand [63:32], second_operand [95:64]
   input  wire logic [95:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // handled [0], write_enable [1], dest_register [6:2], write_value [38:7], zero [39]
   output      logic [39:0] rsp_tdata
);

   logic     dec_valid;
   logic     dec_ready;
   pipe_type dec_data;
   logic     stg_valid [0:DIV_STEPS];
   logic     stg_ready [0:DIV_STEPS];
   pipe_type stg_data  [0:DIV_STEPS];
   logic            handled;
   logic            write_enable;
   logic [4:0]      dest_register;
   logic [XLEN-1:0] write_value;

   // Decode stage
   rmdu_decode u_decode (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .instruction    (req_tdata[31:0]),
      .first_operand  (req_tdata[63:32]),
      .second_operand (req_tdata[95:64]),
      .out_valid      (dec_valid),
      .out_ready      (dec_ready),
      .out_data       (dec_data)
   );

   // Multiply stage
   rmdu_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_data  (stg_data[0])
   );

   // Divider steps
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      rmdu_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[i]),
         .in_ready  (stg_ready[i]),
         .in_data   (stg_data[i]),
         .out_valid (stg_valid[i+1]),
         .out_ready (stg_ready[i+1]),
         .out_data  (stg_data[i+1])
      );
   end

   // Result stage
   rmdu_finish u_finish (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (stg_valid[DIV_STEPS]),
      .in_ready      (stg_ready[DIV_STEPS]),
      .in_data       (stg_data[DIV_STEPS]),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .handled       (handled),
      .write_enable  (write_enable),
      .dest_register (dest_register),
      .write_value   (write_value)
   );

   assign rsp_tdata = {1'b0, write_value, dest_register, write_enable, handled};

   // Checks on the result record and reset behaviour
   `RMDU_ASSERT(a_unmatched_zero, clock, reset, rsp_tvalid && !handled |-> !write_enable && dest_register == 5'd0 && write_value == '0, "unmatched word with non-zero result")
   `RMDU_ASSERT(a_write_needs_rd, clock, reset, rsp_tvalid && write_enable |-> handled && dest_register != 5'd0, "write enable without a valid destination")
   `RMDU_ASSERT(a_rd_zero_no_write, clock, reset, rsp_tvalid && handled && dest_register == 5'd0 |-> !write_enable, "write enable for x0")
   `RMDU_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_tvalid, "result valid straight after reset")

endmodule
`default_nettype wire
